/* rtl/gsc_pkg.sv */
// Shared types, codes and constants for the growable stack block.
`timescale 1ns / 1ps
`default_nettype none

package gsc_pkg;

    // Fixed field widths
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 8;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 2;
    localparam int CMP_W     = CAP_W + 1;
    localparam int DEPTH_DEF = 64;

    // Value reported in place of an element when the stack is empty
    localparam logic signed [DATA_W-1:0] NEG_ONE = '1;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_DUMP  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    // Source of the item_value field of a result
    typedef enum logic [1:0] {
        ITEM_ZERO = 2'd0,
        ITEM_NEG  = 2'd1,
        ITEM_POP  = 2'd2,
        ITEM_MEM  = 2'd3
    } item_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              do_push;
        logic              do_pop;
        logic              pop_done;
        logic              dump_start;
        logic              dump_step;
        logic              res_valid;
        item_sel_t         item_sel;
        logic [STAT_W-1:0] res_status;
        logic              res_last;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_empty;
        logic is_full;
        logic dump_last;
    } dp_stat_t;

    // One result item
    typedef struct packed {
        logic signed [DATA_W-1:0] item_value;
        logic [CAP_W-1:0]         capacity;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [STAT_W-1:0]        status;
        logic                     last;
    } result_t;

endpackage

`default_nettype wire

/* rtl/gsc_ctrl.sv */
// Controller state machine: decodes operations and sequences pops and dumps.
`timescale 1ns / 1ps
`default_nettype none

module gsc_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [gsc_pkg::FUNC_W-1:0]  s_func,
    input  wire gsc_pkg::dp_stat_t           dp_stat,
    input  wire logic                        res_ready,
    output gsc_pkg::cmd_t                    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'b001,
        ST_POP_WAIT = 3'b010,
        ST_DUMP     = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // An item is taken only in idle and only when the result buffer has room.
    assign s_ready = (state_reg == ST_IDLE) && res_ready;
    assign accept  = s_valid && s_ready;

    // Next state and command decode
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.item_sel   = gsc_pkg::ITEM_ZERO;
        cmd.res_status = gsc_pkg::STAT_OK;
        cmd.res_last   = 1'b1;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_func)
                        gsc_pkg::FUNC_PUSH: begin
                            cmd.res_valid = 1'b1;
                            if (dp_stat.is_full) begin
                                cmd.res_status = gsc_pkg::STAT_OVERFLOW;
                            end else begin
                                cmd.do_push = 1'b1;
                            end
                        end
                        gsc_pkg::FUNC_POP: begin
                            if (dp_stat.is_empty) begin
                                cmd.res_valid  = 1'b1;
                                cmd.item_sel   = gsc_pkg::ITEM_NEG;
                                cmd.res_status = gsc_pkg::STAT_EMPTY;
                            end else begin
                                cmd.do_pop = 1'b1;
                                state_next = ST_POP_WAIT;
                            end
                        end
                        gsc_pkg::FUNC_QUERY: begin
                            cmd.res_valid = 1'b1;
                        end
                        gsc_pkg::FUNC_DUMP: begin
                            if (dp_stat.is_empty) begin
                                cmd.res_valid  = 1'b1;
                                cmd.item_sel   = gsc_pkg::ITEM_NEG;
                                cmd.res_status = gsc_pkg::STAT_EMPTY;
                            end else begin
                                cmd.dump_start = 1'b1;
                                state_next     = ST_DUMP;
                            end
                        end
                        default: begin
                            cmd.res_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_POP_WAIT: begin
                // The new top arrives from the store; report the popped value.
                cmd.res_valid = 1'b1;
                cmd.item_sel  = gsc_pkg::ITEM_POP;
                if (res_ready) begin
                    cmd.pop_done = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DUMP: begin
                // One element per transfer, bottom to top.
                cmd.res_valid = 1'b1;
                cmd.item_sel  = gsc_pkg::ITEM_MEM;
                cmd.res_last  = dp_stat.dump_last;
                if (res_ready) begin
                    if (dp_stat.dump_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.dump_step = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/gsc_dp.sv */
// Datapath: element store, count, allocation size, top and bottom values.
`timescale 1ns / 1ps
`default_nettype none

module gsc_dp #(
    parameter int DEPTH = gsc_pkg::DEPTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic signed [gsc_pkg::DATA_W-1:0]  s_push_value,
    input  wire gsc_pkg::cmd_t                      cmd,
    output gsc_pkg::dp_stat_t                       dp_stat,
    output gsc_pkg::result_t                        res
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    logic signed [gsc_pkg::DATA_W-1:0] store_mem [DEPTH];
    logic signed [gsc_pkg::DATA_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]                  count_reg,  count_next;
    logic [gsc_pkg::CAP_W-1:0]         alloc_reg,  alloc_next;
    logic signed [gsc_pkg::DATA_W-1:0] top_reg,    top_next;
    logic signed [gsc_pkg::DATA_W-1:0] bottom_reg, bottom_next;
    logic signed [gsc_pkg::DATA_W-1:0] item_reg,   item_next;
    logic [ADDR_W-1:0]                 idx_reg,    idx_next;

    logic [CNT_W-1:0]                  cnt_m1;
    logic [CNT_W-1:0]                  cnt_m2;
    logic [gsc_pkg::CAP_W-1:0]         alloc_dbl;
    logic [gsc_pkg::CAP_W-1:0]         alloc_half;
    logic [gsc_pkg::CAP_W-1:0]         alloc_shr;
    logic                              grow;
    logic                              shrink;
    logic                              rd_en;
    logic [ADDR_W-1:0]                 rd_addr;
    logic [ADDR_W-1:0]                 idx_inc;

    logic [CNT_W-1:0]                  cnt_view;
    logic [gsc_pkg::CAP_W-1:0]         alloc_view;
    logic signed [gsc_pkg::DATA_W-1:0] top_view;
    logic                              empty_view;

    assign cnt_m1  = count_reg - CNT_W'(1);
    assign cnt_m2  = count_reg - CNT_W'(2);
    assign idx_inc = idx_reg + ADDR_W'(1);

    // Size doubling on push and halving on pop
    assign grow       = (gsc_pkg::CMP_W'(count_reg) + gsc_pkg::CMP_W'(1))
                        >= gsc_pkg::CMP_W'(alloc_reg);
    assign alloc_dbl  = {alloc_reg[gsc_pkg::CAP_W-2:0], 1'b0};
    assign alloc_shr  = alloc_reg >> 1;
    assign shrink     = gsc_pkg::CMP_W'(cnt_m1) < gsc_pkg::CMP_W'(alloc_shr);
    assign alloc_half = (alloc_shr == '0) ? gsc_pkg::CAP_W'(1) : alloc_shr;

    // Status toward the controller
    assign dp_stat.is_empty  = (count_reg == '0);
    assign dp_stat.is_full   = (count_reg == CNT_W'(DEPTH));
    assign dp_stat.dump_last = (CNT_W'(idx_reg) == cnt_m1);

    // Next state of the stack registers
    always_comb begin
        count_next  = count_reg;
        alloc_next  = alloc_reg;
        top_next    = top_reg;
        bottom_next = bottom_reg;
        item_next   = item_reg;
        if (cmd.do_push) begin
            count_next = count_reg + CNT_W'(1);
            alloc_next = grow ? alloc_dbl : alloc_reg;
            top_next   = s_push_value;
            if (count_reg == '0) begin
                bottom_next = s_push_value;
            end
        end else if (cmd.do_pop) begin
            count_next = cnt_m1;
            alloc_next = shrink ? alloc_half : alloc_reg;
            item_next  = top_reg;
        end else if (cmd.pop_done) begin
            top_next = rd_data_reg;
        end
    end

    // Dump index and store read port
    always_comb begin
        idx_next = idx_reg;
        rd_en    = 1'b0;
        rd_addr  = idx_inc;
        if (cmd.do_pop) begin
            rd_en   = 1'b1;
            rd_addr = cnt_m2[ADDR_W-1:0];
        end else if (cmd.dump_start) begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            idx_next = '0;
        end else if (cmd.dump_step) begin
            rd_en    = 1'b1;
            idx_next = idx_inc;
        end
    end

    // State after this operation, as the result reports it
    assign cnt_view   = cmd.do_push ? count_next : count_reg;
    assign alloc_view = cmd.do_push ? alloc_next : alloc_reg;
    assign empty_view = (cnt_view == '0);
    always_comb begin
        if (cmd.do_push) begin
            top_view = s_push_value;
        end else if (cmd.item_sel == gsc_pkg::ITEM_POP) begin
            top_view = rd_data_reg;
        end else begin
            top_view = top_reg;
        end
    end

    // Result assembly
    always_comb begin
        case (cmd.item_sel)
            gsc_pkg::ITEM_NEG: res.item_value = gsc_pkg::NEG_ONE;
            gsc_pkg::ITEM_POP: res.item_value = item_reg;
            gsc_pkg::ITEM_MEM: res.item_value = rd_data_reg;
            default:           res.item_value = '0;
        endcase
        res.capacity    = alloc_view;
        res.is_empty    = empty_view;
        res.front_value = empty_view ? gsc_pkg::NEG_ONE : bottom_next;
        res.back_value  = empty_view ? gsc_pkg::NEG_ONE : top_view;
        res.status      = cmd.res_status;
        res.last        = cmd.res_last;
    end

    // Element store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.do_push) begin
            store_mem[count_reg[ADDR_W-1:0]] <= s_push_value;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Stack registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            alloc_reg  <= gsc_pkg::CAP_W'(1);
            bottom_reg <= '0;
        end else begin
            count_reg  <= count_next;
            alloc_reg  <= alloc_next;
            bottom_reg <= bottom_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        top_reg  <= top_next;
        item_reg <= item_next;
        idx_reg  <= idx_next;
    end

endmodule

`default_nettype wire

/* rtl/gsc_obuf.sv */
// Result buffer: output register with a skid stage behind it.
`timescale 1ns / 1ps
`default_nettype none

module gsc_obuf (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gsc_pkg::result_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gsc_pkg::result_t       out_data
);

    logic             out_valid_reg,  out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    gsc_pkg::result_t out_reg,        out_next;
    gsc_pkg::result_t skid_reg,       skid_next;
    logic             in_xfer;

    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Refill the output register from the skid stage first, then from the input.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_xfer) begin
                out_next       = in_data;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (in_xfer) begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

/* rtl/growable_stack_with_capacity.sv */
// Push, query and error results reach m_ via the result buffer's output register; a new
// item may follow while the buffer has room. A pop fetches the new top via the store's
// registered read port and reports from the pop-wait state. A dump sends one result per
// element, bottom to top, through the store's one read port. No item is taken until a pop
// or dump has handed on its last result. Synchronous active-low reset empties the stack,
// sets the size to one and clears the result buffer; the element store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module growable_stack_with_capacity #(
    parameter int DEPTH = gsc_pkg::DEPTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [gsc_pkg::FUNC_W-1:0]         s_func,
    input  wire logic signed [gsc_pkg::DATA_W-1:0]  s_push_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [gsc_pkg::DATA_W-1:0]       m_item_value,
    output logic [gsc_pkg::CAP_W-1:0]               m_capacity,
    output logic                                    m_is_empty,
    output logic signed [gsc_pkg::DATA_W-1:0]       m_front_value,
    output logic signed [gsc_pkg::DATA_W-1:0]       m_back_value,
    output logic [gsc_pkg::STAT_W-1:0]              m_status,
    output logic                                    m_last
);

    gsc_pkg::cmd_t     cmd;
    gsc_pkg::dp_stat_t dp_stat;
    gsc_pkg::result_t  res;
    gsc_pkg::result_t  out_data;
    logic              res_ready;

    gsc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .dp_stat   (dp_stat),
        .res_ready (res_ready),
        .cmd       (cmd)
    );

    gsc_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_push_value (s_push_value),
        .cmd          (cmd),
        .dp_stat      (dp_stat),
        .res          (res)
    );

    gsc_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd.res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    // Unpack the result onto the m_ channel
    assign m_item_value  = out_data.item_value;
    assign m_capacity    = out_data.capacity;
    assign m_is_empty    = out_data.is_empty;
    assign m_front_value = out_data.front_value;
    assign m_back_value  = out_data.back_value;
    assign m_status      = out_data.status;
    assign m_last        = out_data.last;

endmodule

`default_nettype wire

/* dv/tb_growable_stack_with_capacity.sv */
// Self-checking testbench for the growable stack: random traffic, shadow stack, result checks.
`timescale 1ns / 1ps

module tb_growable_stack_with_capacity;

    localparam int STACK_DEPTH  = gsc_pkg::DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int RANDOM_ITEMS = 230;
    localparam int IDLE_PCT     = 9;
    localparam int HOLD_AT_ITEM = 30;
    localparam int HOLD_CYCLES  = 200;
    localparam int PRINT_CAP    = 100;

    // One operation waiting to be offered on the input channel.
    typedef struct packed {
        logic [gsc_pkg::FUNC_W-1:0]        op;
        logic signed [gsc_pkg::DATA_W-1:0] value;
    } stack_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [gsc_pkg::FUNC_W-1:0]        s_func = gsc_pkg::FUNC_QUERY;
    logic signed [gsc_pkg::DATA_W-1:0] s_push_value = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic signed [gsc_pkg::DATA_W-1:0] m_item_value;
    logic [gsc_pkg::CAP_W-1:0]         m_capacity;
    logic                              m_is_empty;
    logic signed [gsc_pkg::DATA_W-1:0] m_front_value;
    logic signed [gsc_pkg::DATA_W-1:0] m_back_value;
    logic [gsc_pkg::STAT_W-1:0]        m_status;
    logic                              m_last;

    growable_stack_with_capacity #(
        .DEPTH(STACK_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item_value (m_item_value),
        .m_capacity   (m_capacity),
        .m_is_empty   (m_is_empty),
        .m_front_value(m_front_value),
        .m_back_value (m_back_value),
        .m_status     (m_status),
        .m_last       (m_last)
    );

    always #4 aclk = ~aclk;

    // Operations still to be offered, and results the block owes us.
    stack_req_t        pending_ops[$];
    gsc_pkg::result_t  expected_results[$];
    stack_req_t        next_op;
    gsc_pkg::result_t  observed;

    // Shadow copy of the stack, advanced once per accepted transfer.
    logic signed [gsc_pkg::DATA_W-1:0] shadow_elems [STACK_DEPTH];
    int                                shadow_count = 0;
    int                                shadow_size = 1;
    logic signed [gsc_pkg::DATA_W-1:0] shadow_bottom = '0;

    // Bookkeeping.
    int accepted_ops = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int n_push = 0, n_overflow = 0, n_pop = 0, n_pop_empty = 0;
    int n_query = 0, n_dump = 0, n_dump_empty = 0;
    int deepest = 0, widest = 1;

    // Generator-side view of the depth, used only to steer the stimulus.
    int gen_count = 0;
    int gen_overflows = 0;
    int gen_empty_pops = 0;
    int random_ops = 0;

    // Neither side idles while this window of transfers is in progress.
    wire calm = (accepted_ops >= 60) && (accepted_ops < 130);

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string name, input logic [gsc_pkg::DATA_W-1:0] got,
                                 input logic [gsc_pkg::DATA_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d, %s: got %h, expected %h",
                                      results_checked, name, got, want));
        end
    endtask

    task automatic check_result(input gsc_pkg::result_t got, input gsc_pkg::result_t want);
        compare_field("item_value", got.item_value, want.item_value);
        compare_field("capacity", gsc_pkg::DATA_W'(got.capacity),
                      gsc_pkg::DATA_W'(want.capacity));
        compare_field("is_empty", gsc_pkg::DATA_W'(got.is_empty),
                      gsc_pkg::DATA_W'(want.is_empty));
        compare_field("front_value", got.front_value, want.front_value);
        compare_field("back_value", got.back_value, want.back_value);
        compare_field("status", gsc_pkg::DATA_W'(got.status), gsc_pkg::DATA_W'(want.status));
        compare_field("last", gsc_pkg::DATA_W'(got.last), gsc_pkg::DATA_W'(want.last));
    endtask

    // Append one expected result built from the current shadow state.
    task automatic queue_result(input logic signed [gsc_pkg::DATA_W-1:0] item,
                                input logic [gsc_pkg::STAT_W-1:0] stat,
                                input logic final_one);
        gsc_pkg::result_t r;
        r.item_value  = item;
        r.capacity    = gsc_pkg::CAP_W'(shadow_size);
        r.is_empty    = (shadow_count == 0);
        r.front_value = (shadow_count == 0) ? gsc_pkg::NEG_ONE : shadow_bottom;
        r.back_value  = (shadow_count == 0) ? gsc_pkg::NEG_ONE
                                            : shadow_elems[shadow_count-1];
        r.status      = stat;
        r.last        = final_one;
        expected_results.push_back(r);
    endtask

    // Apply one operation to the shadow stack and queue what it must produce.
    task automatic predict_stack_op(input logic [gsc_pkg::FUNC_W-1:0] op,
                                    input logic signed [gsc_pkg::DATA_W-1:0] value);
        logic signed [gsc_pkg::DATA_W-1:0] popped;
        case (op)
            gsc_pkg::FUNC_PUSH: begin
                if (shadow_count >= STACK_DEPTH) begin
                    n_overflow++;
                    queue_result('0, gsc_pkg::STAT_OVERFLOW, 1'b1);
                end else begin
                    n_push++;
                    if (shadow_count + 1 >= shadow_size) begin
                        shadow_size = (shadow_size * 2) & 255;
                    end
                    shadow_elems[shadow_count] = value;
                    if (shadow_count == 0) begin
                        shadow_bottom = value;
                    end
                    shadow_count++;
                    queue_result('0, gsc_pkg::STAT_OK, 1'b1);
                end
            end
            gsc_pkg::FUNC_POP: begin
                if (shadow_count == 0) begin
                    n_pop_empty++;
                    queue_result(gsc_pkg::NEG_ONE, gsc_pkg::STAT_EMPTY, 1'b1);
                end else begin
                    n_pop++;
                    popped = shadow_elems[shadow_count-1];
                    // Halve before the count drops; the size never goes below one.
                    if (shadow_count - 1 < shadow_size / 2) begin
                        shadow_size = shadow_size / 2;
                        if (shadow_size == 0) begin
                            shadow_size = 1;
                        end
                    end
                    shadow_count--;
                    queue_result(popped, gsc_pkg::STAT_OK, 1'b1);
                end
            end
            gsc_pkg::FUNC_QUERY: begin
                n_query++;
                queue_result('0, gsc_pkg::STAT_OK, 1'b1);
            end
            default: begin
                if (shadow_count == 0) begin
                    n_dump_empty++;
                    queue_result(gsc_pkg::NEG_ONE, gsc_pkg::STAT_EMPTY, 1'b1);
                end else begin
                    n_dump++;
                    for (int i = 0; i < shadow_count; i++) begin
                        queue_result(shadow_elems[i], gsc_pkg::STAT_OK, i == shadow_count - 1);
                    end
                end
            end
        endcase
        if (shadow_count > deepest) deepest = shadow_count;
        if (shadow_size > widest) widest = shadow_size;
    endtask

    // Queue an operation and track the depth it leaves behind.
    task automatic add_op(input logic [gsc_pkg::FUNC_W-1:0] op,
                          input logic signed [gsc_pkg::DATA_W-1:0] value);
        stack_req_t req;
        req.op    = op;
        req.value = value;
        pending_ops.push_back(req);
        if (op == gsc_pkg::FUNC_PUSH) begin
            if (gen_count == STACK_DEPTH) gen_overflows++;
            else gen_count++;
        end else if (op == gsc_pkg::FUNC_POP) begin
            if (gen_count == 0) gen_empty_pops++;
            else gen_count--;
        end
    endtask

    // Mostly full-range random values, now and then a corner value.
    function automatic logic signed [gsc_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return gsc_pkg::NEG_ONE;
            default: return $urandom;
        endcase
    endfunction

    // Pick an operation; push_pct and pop_pct set the drift of the depth.
    task automatic add_random_op(input int push_pct, input int pop_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_pct) add_op(gsc_pkg::FUNC_PUSH, pick_value());
        else if (roll < push_pct + pop_pct) add_op(gsc_pkg::FUNC_POP, pick_value());
        else if (roll < push_pct + pop_pct + (100 - push_pct - pop_pct) / 2)
            add_op(gsc_pkg::FUNC_QUERY, pick_value());
        else add_op(gsc_pkg::FUNC_DUMP, pick_value());
        random_ops++;
    endtask

    // Sender: offer the next operation once the previous transfer is done.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_stack_op(s_func, s_push_value);
                accepted_ops <= accepted_ops + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_ops.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    next_op = pending_ops.pop_front();
                    s_valid      <= 1'b1;
                    s_func       <= next_op.op;
                    s_push_value <= next_op.value;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, once, so the block backs up and stalls its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_ops >= HOLD_AT_ITEM) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: check each result transfer against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                observed.item_value  = m_item_value;
                observed.capacity    = m_capacity;
                observed.is_empty    = m_is_empty;
                observed.front_value = m_front_value;
                observed.back_value  = m_back_value;
                observed.status      = m_status;
                observed.last        = m_last;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_checked));
                end else begin
                    check_result(observed, expected_results.pop_front());
                end
                results_checked++;
            end
            m_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int drain_cycles;
        int total_ops;

        // Directed: empty-stack errors, corner values, dump and pop back to empty.
        add_op(gsc_pkg::FUNC_QUERY, '0);
        add_op(gsc_pkg::FUNC_POP, '0);
        add_op(gsc_pkg::FUNC_DUMP, '0);
        add_op(gsc_pkg::FUNC_PUSH, 32'sh7FFF_FFFF);
        add_op(gsc_pkg::FUNC_PUSH, 32'sh8000_0000);
        add_op(gsc_pkg::FUNC_PUSH, '0);
        add_op(gsc_pkg::FUNC_PUSH, gsc_pkg::NEG_ONE);
        add_op(gsc_pkg::FUNC_PUSH, 32'sh5555_5555);
        add_op(gsc_pkg::FUNC_PUSH, 32'shAAAA_AAAA);
        add_op(gsc_pkg::FUNC_QUERY, gsc_pkg::NEG_ONE);
        add_op(gsc_pkg::FUNC_DUMP, gsc_pkg::NEG_ONE);
        for (int i = 0; i < 5; i++) add_op(gsc_pkg::FUNC_POP, '0);
        add_op(gsc_pkg::FUNC_QUERY, '0);
        add_op(gsc_pkg::FUNC_POP, '0);
        add_op(gsc_pkg::FUNC_POP, '0);
        add_op(gsc_pkg::FUNC_PUSH, 32'sd1);
        add_op(gsc_pkg::FUNC_DUMP, '0);
        add_op(gsc_pkg::FUNC_POP, '0);

        // Fill until the stack is full and several pushes have been refused.
        while (!(gen_count == STACK_DEPTH && gen_overflows >= 3) && random_ops < 400) begin
            add_random_op(80, 8);
        end
        add_op(gsc_pkg::FUNC_DUMP, pick_value());
        random_ops++;

        // Drain back to empty, with a few pops on the empty stack.
        while (!(gen_count == 0 && gen_empty_pops >= 2) && random_ops < 800) begin
            add_random_op(8, 80);
        end

        // Unbiased mix for the rest of the run.
        do begin
            add_random_op(35, 30);
        end while (random_ops < RANDOM_ITEMS);

        total_ops = pending_ops.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every operation to be taken, then for every result.
        while (accepted_ops < total_ops) @(posedge aclk);
        drain_cycles = 0;
        while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        end
        repeat (20) @(posedge aclk);

        $display("Ran %0d operations: %0d pushes, %0d refused on full, %0d pops, %0d on empty,",
                 accepted_ops, n_push, n_overflow, n_pop, n_pop_empty);
        $display("%0d queries, %0d dumps, %0d on empty; %0d results, depth up to %0d, size up to %0d",
                 n_query, n_dump, n_dump_empty, results_checked, deepest, widest);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/gsc_pkg.sv
rtl/gsc_ctrl.sv
rtl/gsc_dp.sv
rtl/gsc_obuf.sv
rtl/growable_stack_with_capacity.sv
dv/tb_growable_stack_with_capacity.sv
